// File: rtl/core/mbe_pkg.sv
// Shared types, constants and helpers for the escape-time unit.
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int unsigned ZW        = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REAL_ORIGIN = 3'd0,
    CFG_IMAG_ORIGIN = 3'd1,
    CFG_REAL_STEP   = 3'd2,
    CFG_IMAG_STEP   = 3'd3,
    CFG_MAX_ITER    = 3'd4
  } cfg_idx_e;

  localparam logic signed [ZW-1:0]     ORIGIN_RST = 32'shE000_0000;
  localparam logic [STEP_W-1:0]        STEP_RST   = 31'd1048576;
  localparam logic [CFG_DATA_W-1:0]    ITER_RST   = 32'd1000;

  typedef struct packed {
    logic signed [ZW-1:0] real_origin;
    logic signed [ZW-1:0] imag_origin;
    logic [STEP_W-1:0]    real_step;
    logic [STEP_W-1:0]    imag_step;
  } mbe_cfg_t;

  function automatic logic signed [ZW-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[ZW-1:0];
    end
  endfunction

endpackage

// File: rtl/core/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time unit.
`timescale 1ns / 1ps
//
// One pixel word enters on the s_axis channel (row, column) and one result word
// leaves on m_axis (row, column, iteration count, escaped flag).
// The pixel is mapped to c = origin + index * step per axis, then z = z*z + c
// runs from zero until |z|^2 >= 4 or max_iterations is reached.
// All products go through a single registered 32x32 multiplier: mapping
// multiplies column and row by their steps, each iteration computes re^2,
// im^2 and re*im and then updates z, and the final magnitude check squares
// both parts once more.
// s_axis_tready is high only while no pixel is in work; one pixel at a time.
// The result sits in an output register, so the next pixel is taken while the
// previous result waits; a stalled receiver only holds the unit once a second
// result is ready to be written.
// Config writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered and
// must only be issued while the unit is idle.
// Reset restores origin -2.0/-2.0, steps 4/1024 and a limit of 1000, and
// empties the output register.

module mandelbrot_escape_time #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 28,
  parameter int unsigned ITER_BITS  = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // row, column
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pixel_row, pixel_column, iterations, escaped
  output logic [((2*COORD_BITS+ITER_BITS+1+7)/8)*8-1:0] m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned OUT_BITS = 2*COORD_BITS + ITER_BITS + 1;

  mbe_pkg::mbe_cfg_t                 cfg;
  logic [ITER_BITS-1:0]              max_iter;
  logic signed [mbe_pkg::ZW-1:0]     op_a, op_b;
  logic signed [mbe_pkg::PROD_W-1:0] prod;
  logic [COORD_BITS-1:0]             res_row, res_col;
  logic [ITER_BITS-1:0]              res_iter;
  logic                              res_esc;

  mbe_cfg #(
    .ITER_BITS (ITER_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .max_iter_o  (max_iter)
  );

  mbe_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  mbe_seq #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .row_i      (s_axis_tdata[COORD_BITS-1:0]),
    .col_i      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .cfg_i      (cfg),
    .max_iter_i (max_iter),
    .prod_i     (prod),
    .op_a_o     (op_a),
    .op_b_o     (op_b),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .res_row_o  (res_row),
    .res_col_o  (res_col),
    .res_iter_o (res_iter),
    .res_esc_o  (res_esc)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[OUT_BITS-1:0] = {res_esc, res_iter, res_col, res_row};
  end

endmodule

// File: rtl/core/mbe_cfg.sv
// Configuration register file for the escape-time unit.
`timescale 1ns / 1ps

module mbe_cfg #(
  parameter int unsigned ITER_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output mbe_pkg::mbe_cfg_t                 cfg_o,
  output logic [ITER_BITS-1:0]              max_iter_o
);

  mbe_pkg::mbe_cfg_t    cfg_q;
  logic [ITER_BITS-1:0] max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_origin <= mbe_pkg::ORIGIN_RST;
      cfg_q.imag_origin <= mbe_pkg::ORIGIN_RST;
      cfg_q.real_step   <= mbe_pkg::STEP_RST;
      cfg_q.imag_step   <= mbe_pkg::STEP_RST;
      max_iter_q        <= mbe_pkg::ITER_RST[ITER_BITS-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mbe_pkg::CFG_REAL_ORIGIN: cfg_q.real_origin <= cfg_data_i;
        mbe_pkg::CFG_IMAG_ORIGIN: cfg_q.imag_origin <= cfg_data_i;
        mbe_pkg::CFG_REAL_STEP:   cfg_q.real_step   <= cfg_data_i[mbe_pkg::STEP_W-1:0];
        mbe_pkg::CFG_IMAG_STEP:   cfg_q.imag_step   <= cfg_data_i[mbe_pkg::STEP_W-1:0];
        mbe_pkg::CFG_MAX_ITER:    max_iter_q        <= cfg_data_i[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o      = cfg_q;
  assign max_iter_o = max_iter_q;

endmodule

// File: rtl/core/mbe_mul.sv
// Shared 32x32 signed multiplier with registered product.
`timescale 1ns / 1ps

module mbe_mul (
  input  logic                               clk_i,
  input  logic signed [mbe_pkg::ZW-1:0]      op_a_i,
  input  logic signed [mbe_pkg::ZW-1:0]      op_b_i,
  output logic signed [mbe_pkg::PROD_W-1:0]  prod_o
);

  logic signed [mbe_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mbe_pkg::PROD_W'(op_a_i) * mbe_pkg::PROD_W'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/core/mbe_seq.sv
// Sequencer and iterate registers: maps the pixel, then runs z = z*z + c.
`timescale 1ns / 1ps

module mbe_seq #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 28,
  parameter int unsigned ITER_BITS  = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_valid_i,
  output logic                               s_ready_o,
  input  logic [COORD_BITS-1:0]              row_i,
  input  logic [COORD_BITS-1:0]              col_i,
  input  mbe_pkg::mbe_cfg_t                  cfg_i,
  input  logic [ITER_BITS-1:0]               max_iter_i,
  input  logic signed [mbe_pkg::PROD_W-1:0]  prod_i,
  output logic signed [mbe_pkg::ZW-1:0]      op_a_o,
  output logic signed [mbe_pkg::ZW-1:0]      op_b_o,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic [COORD_BITS-1:0]              res_row_o,
  output logic [COORD_BITS-1:0]              res_col_o,
  output logic [ITER_BITS-1:0]               res_iter_o,
  output logic                               res_esc_o
);

  localparam int unsigned ZW     = mbe_pkg::ZW;
  localparam int unsigned PW     = mbe_pkg::PROD_W;
  // squares are at most 2^62, so the scaled square fits in 63-F bits
  localparam int unsigned SQ_W   = PW - 1 - FRAC_BITS;
  localparam logic [PW-1:0] LIMIT = 64'd4 << FRAC_BITS;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_MAP_RE  = 9'b000000010,
    ST_MAP_IM  = 9'b000000100,
    ST_MAP_END = 9'b000001000,
    ST_SQ_RE   = 9'b000010000,
    ST_SQ_IM   = 9'b000100000,
    ST_CROSS   = 9'b001000000,
    ST_UPDATE  = 9'b010000000,
    ST_DONE    = 9'b100000000
  } st_e;

  st_e st_q, st_d;

  logic [COORD_BITS-1:0]  row_q, col_q;
  logic signed [ZW-1:0]   c_re_q, c_im_q, re_q, im_q;
  logic [SQ_W-1:0]        a_q, b_q;
  logic [ITER_BITS-1:0]   iter_q;
  logic                   esc_q;

  logic                   m_valid_q;
  logic [COORD_BITS-1:0]  res_row_q, res_col_q;
  logic [ITER_BITS-1:0]   res_iter_q;
  logic                   res_esc_q;

  logic [SQ_W-1:0]        sq_now;
  logic [SQ_W:0]          lsq;
  logic                   escape;
  logic                   stop;
  logic signed [PW-1:0]   re_sum, im_sum;
  logic                   out_free;

  assign sq_now = prod_i[PW-2:FRAC_BITS];
  assign lsq    = {1'b0, a_q} + {1'b0, sq_now};
  assign escape = {{(PW-SQ_W-1){1'b0}}, lsq} >= LIMIT;
  assign stop   = escape || (iter_q >= max_iter_i);
  assign re_sum = $signed({{(PW-SQ_W){1'b0}}, a_q}) - $signed({{(PW-SQ_W){1'b0}}, b_q})
                  + PW'(c_re_q);
  assign im_sum = (prod_i >>> (FRAC_BITS - 1)) + PW'(c_im_q);
  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    unique case (st_q)
      ST_MAP_RE: begin
        op_a_o = $signed({{(ZW-COORD_BITS){1'b0}}, col_q});
        op_b_o = $signed({1'b0, cfg_i.real_step});
      end
      ST_MAP_IM: begin
        op_a_o = $signed({{(ZW-COORD_BITS){1'b0}}, row_q});
        op_b_o = $signed({1'b0, cfg_i.imag_step});
      end
      ST_SQ_RE: begin
        op_a_o = re_q;
        op_b_o = re_q;
      end
      ST_SQ_IM: begin
        op_a_o = im_q;
        op_b_o = im_q;
      end
      default: begin
        op_a_o = re_q;
        op_b_o = im_q;
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:    if (s_valid_i) st_d = ST_MAP_RE;
      ST_MAP_RE:  st_d = ST_MAP_IM;
      ST_MAP_IM:  st_d = ST_MAP_END;
      ST_MAP_END: st_d = ST_SQ_RE;
      ST_SQ_RE:   st_d = ST_SQ_IM;
      ST_SQ_IM:   st_d = ST_CROSS;
      ST_CROSS:   st_d = stop ? ST_DONE : ST_UPDATE;
      ST_UPDATE:  st_d = ST_SQ_RE;
      ST_DONE:    if (out_free) st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        row_q  <= row_i;
        col_q  <= col_i;
        re_q   <= '0;
        im_q   <= '0;
        a_q    <= '0;
        iter_q <= '0;
      end
      ST_MAP_IM:  c_re_q <= mbe_pkg::sat32(PW'(cfg_i.real_origin) + prod_i);
      ST_MAP_END: c_im_q <= mbe_pkg::sat32(PW'(cfg_i.imag_origin) + prod_i);
      ST_SQ_IM:   a_q    <= sq_now;
      ST_CROSS: begin
        b_q   <= sq_now;
        esc_q <= escape;
      end
      ST_UPDATE: begin
        re_q   <= mbe_pkg::sat32(re_sum);
        im_q   <= mbe_pkg::sat32(im_sum);
        iter_q <= iter_q + 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          res_row_q  <= row_q;
          res_col_q  <= col_q;
          res_iter_q <= iter_q;
          res_esc_q  <= esc_q;
        end
      end
      default: ;
    endcase
  end

  assign s_ready_o  = (st_q == ST_IDLE);
  assign m_valid_o  = m_valid_q;
  assign res_row_o  = res_row_q;
  assign res_col_o  = res_col_q;
  assign res_iter_o = res_iter_q;
  assign res_esc_o  = res_esc_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && st_q == ST_IDLE) |=> (st_q == ST_MAP_RE))
    else $error("accepted word did not start mapping");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(st_q == ST_DONE))
    else $error("result valid raised outside done state");

  a_escape_needs_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_esc_q) |-> (res_iter_q != '0))
    else $error("escape reported with zero iterations");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_ready_o)
    else $error("input ready while busy");

endmodule
